// ===== design/assert_macros.svh =====
// Assertion helpers, included by the top-level unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Check that a condition never occurs outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

// ===== design/c2p_pkg.sv =====
`timescale 1ns / 1ps

package c2p_pkg;

   localparam int GLYPH_ROWS    = 7;
   localparam int GLYPH_COLS    = 5;
   localparam int CHAR_SKIP_MIN = 128;
   localparam int CASE_FOLD     = 32;
   localparam int ADVANCE_DOTS  = 6;

   // One glyph: row 0 on top, bit 4 of each row is the leftmost dot
   typedef logic [0:GLYPH_ROWS-1][GLYPH_COLS-1:0] glyph_type;

   // One queued character word, ready for cell emission
   typedef struct packed {
      logic [15:0] cursor_x;
      logic [15:0] start_y;
      logic [6:0]  glyph_char;
      logic [3:0]  scale;
      logic [15:0] fg_color;
      logic [15:0] bg_color;
   } entry_type;

   // Fold lower case and look up the 5x7 font; unknown codes draw blank
   function automatic glyph_type font_glyph(input logic [6:0] code);
      logic [6:0] up;
      glyph_type  g;
      up = code;
      if (up >= 7'("a") && up <= 7'("z")) begin
         up = up - 7'(CASE_FOLD);
      end
      case (up)
         7'("."): g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C};
         7'("/"): g = {5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h00, 5'h00};
         7'("-"): g = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
         7'("%"): g = {5'h19, 5'h1A, 5'h04, 5'h08, 5'h16, 5'h06, 5'h00};
         7'("0"): g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
         7'("1"): g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
         7'("2"): g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
         7'("3"): g = {5'h1E, 5'h01, 5'h01, 5'h06, 5'h01, 5'h01, 5'h1E};
         7'("4"): g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
         7'("5"): g = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
         7'("6"): g = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
         7'("7"): g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
         7'("8"): g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
         7'("9"): g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h1C};
         7'("A"): g = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
         7'("B"): g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
         7'("C"): g = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
         7'("D"): g = {5'h1C, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1C};
         7'("E"): g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
         7'("F"): g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
         7'("G"): g = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F};
         7'("H"): g = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
         7'("I"): g = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
         7'("K"): g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
         7'("L"): g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
         7'("M"): g = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
         7'("N"): g = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
         7'("O"): g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
         7'("P"): g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
         7'("R"): g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
         7'("S"): g = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
         7'("T"): g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
         7'("U"): g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
         7'("V"): g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
         7'("W"): g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
         7'("Y"): g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
         default: g = '0;
      endcase
      return g;
   endfunction

endpackage

// ===== design/c2p_ram.sv =====
`timescale 1ns / 1ps

module c2p_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port, registered read port that holds while not enabled
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/c2p_intake.sv =====
`timescale 1ns / 1ps

module c2p_intake import c2p_pkg::*; #(
   parameter int MAX_SCALE  = 8,
   parameter int FIFO_DEPTH = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic                          req_first_char,
   input  logic [15:0]                   req_start_x,
   input  logic [15:0]                   req_start_y,
   input  logic [7:0]                    req_char_code,
   input  logic [3:0]                    req_pixel_scale,
   input  logic [15:0]                   req_fg_color,
   input  logic [15:0]                   req_bg_color,
   output logic                          wr_en,
   output logic [$clog2(FIFO_DEPTH)-1:0] wr_ptr,
   output entry_type                     wr_entry
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);

   logic             accept;
   logic             drawn;
   logic [3:0]       scale;
   logic [15:0]      base_x;
   logic [15:0]      advance;
   logic [15:0]      cursor_ff;
   logic [15:0]      cursor_in;
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;

   assign accept = req_valid && !req_stall;
   assign drawn  = req_char_code < 8'(CHAR_SKIP_MIN);

   // Clamp scale into 1..MAX_SCALE
   always_comb begin
      scale = (req_pixel_scale == 4'd0) ? 4'd1 : req_pixel_scale;
      if (5'(scale) > 5'(MAX_SCALE)) begin
         scale = 4'(MAX_SCALE);
      end
   end

   // Start position of this character and the cursor step after it
   assign base_x  = req_first_char ? req_start_x : cursor_ff;
   assign advance = 16'(scale) * 16'(ADVANCE_DOTS);

   always_comb begin
      cursor_in = cursor_ff;
      wr_ptr_in = wr_ptr_ff;
      if (accept) begin
         cursor_in = drawn ? base_x + advance : base_x;
         if (drawn) begin
            wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         wr_ptr_ff <= '0;
      end else begin
         cursor_ff <= cursor_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   // Queue the drawn character word
   assign wr_en               = accept && drawn;
   assign wr_ptr              = wr_ptr_ff;
   assign wr_entry.cursor_x   = base_x;
   assign wr_entry.start_y    = req_start_y;
   assign wr_entry.glyph_char = req_char_code[6:0];
   assign wr_entry.scale      = scale;
   assign wr_entry.fg_color   = req_fg_color;
   assign wr_entry.bg_color   = req_bg_color;

endmodule

// ===== design/c2p_emitter.sv =====
`timescale 1ns / 1ps

module c2p_emitter import c2p_pkg::*; #(
   parameter int FIFO_DEPTH = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          avail,
   input  entry_type                     rd_entry,
   output logic                          rd_en,
   output logic [$clog2(FIFO_DEPTH)-1:0] rd_ptr,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [15:0]                   rsp_cell_x,
   output logic [15:0]                   rsp_cell_y,
   output logic [3:0]                    rsp_cell_size,
   output logic [15:0]                   rsp_cell_color,
   output logic                          rsp_last_cell
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);

   logic             active_ff, active_in;
   logic [2:0]       row_ff, row_in;
   logic [2:0]       col_ff, col_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      cell_x_ff, cell_y_ff, cell_color_ff;
   logic [3:0]       cell_size_ff;
   logic             last_cell_ff;
   logic             emit;
   logic             row_end;
   logic             last;
   logic [6:0]       x_off;
   logic [6:0]       y_off;
   glyph_type        glyph;
   logic             dot_on;

   // Emit a cell whenever the output register is free or being drained
   assign emit    = active_ff && (!rsp_valid_ff || !rsp_stall);
   assign row_end = col_ff == 3'(GLYPH_COLS - 1);
   assign last    = row_end && (row_ff == 3'(GLYPH_ROWS - 1));

   // Fetch the next queued word when idle or as the current one hands out its last cell
   assign rd_en = avail && (!active_ff || (emit && last));

   always_comb begin
      active_in    = active_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      rd_ptr_in    = rd_ptr_ff;
      rsp_valid_in = rsp_stall ? rsp_valid_ff : 1'b0;
      if (emit) begin
         rsp_valid_in = 1'b1;
         col_in       = row_end ? 3'd0 : col_ff + 3'd1;
         if (row_end) begin
            row_in = last ? 3'd0 : row_ff + 3'd1;
         end
         if (last) begin
            active_in = 1'b0;
         end
      end
      if (rd_en) begin
         active_in = 1'b1;
         rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         row_ff       <= '0;
         col_ff       <= '0;
         rd_ptr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         rd_ptr_ff    <= rd_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Cell geometry and color for the current dot
   assign x_off  = 7'(col_ff) * 7'(rd_entry.scale);
   assign y_off  = 7'(row_ff) * 7'(rd_entry.scale);
   assign glyph  = font_glyph(rd_entry.glyph_char);
   assign dot_on = glyph[row_ff][3'(GLYPH_COLS - 1) - col_ff];

   // Load the output word
   always_ff @(posedge clock) begin
      if (emit) begin
         cell_x_ff     <= rd_entry.cursor_x + 16'(x_off);
         cell_y_ff     <= rd_entry.start_y + 16'(y_off);
         cell_size_ff  <= rd_entry.scale;
         cell_color_ff <= dot_on ? rd_entry.fg_color : rd_entry.bg_color;
         last_cell_ff  <= last;
      end
   end

   assign rd_ptr         = rd_ptr_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_x     = cell_x_ff;
   assign rsp_cell_y     = cell_y_ff;
   assign rsp_cell_size  = cell_size_ff;
   assign rsp_cell_color = cell_color_ff;
   assign rsp_last_cell  = last_cell_ff;

endmodule

// ===== design/char_to_pixel_cells_5x7_unit.sv =====
// A taken character is written into the queue RAM, read out through the RAM's read register,
// and its cells are loaded into the single output register, one cell per cycle while
// rsp_stall is low; a code of 128 or above is taken but yields no cells.
// Up to FIFO_DEPTH characters wait in the queue RAM while cells are drained.
// Reset clears the cursor to zero, empties the queue and drops any pending cell;
// the queue RAM contents are not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module char_to_pixel_cells_5x7_unit import c2p_pkg::*; #(
   parameter int MAX_SCALE  = 8,
   parameter int FIFO_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_first_char,
   input  logic signed [15:0] req_start_x,
   input  logic signed [15:0] req_start_y,
   input  logic [7:0]         req_char_code,
   input  logic [3:0]         req_pixel_scale,
   input  logic [15:0]        req_fg_color,
   input  logic [15:0]        req_bg_color,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_cell_x,
   output logic signed [15:0] rsp_cell_y,
   output logic [3:0]         rsp_cell_size,
   output logic [15:0]        rsp_cell_color,
   output logic               rsp_last_cell
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   logic             wr_en;
   logic [PTR_W-1:0] wr_ptr;
   entry_type        wr_entry;
   logic             rd_en;
   logic [PTR_W-1:0] rd_ptr;
   entry_type        rd_entry;
   logic [CNT_W-1:0] count_ff, count_in;

   // Hold the input while the queue is full
   assign req_stall = count_ff == CNT_W'(FIFO_DEPTH);

   c2p_intake #(
      .MAX_SCALE  (MAX_SCALE),
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_intake (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_first_char  (req_first_char),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_char_code   (req_char_code),
      .req_pixel_scale (req_pixel_scale),
      .req_fg_color    (req_fg_color),
      .req_bg_color    (req_bg_color),
      .wr_en           (wr_en),
      .wr_ptr          (wr_ptr),
      .wr_entry        (wr_entry)
   );

   c2p_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (FIFO_DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_ptr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr),
      .rd_data (rd_entry)
   );

   c2p_emitter #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_emitter (
      .clock          (clock),
      .reset          (reset),
      .avail          (count_ff != '0),
      .rd_entry       (rd_entry),
      .rd_en          (rd_en),
      .rd_ptr         (rd_ptr),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cell_x     (rsp_cell_x),
      .rsp_cell_y     (rsp_cell_y),
      .rsp_cell_size  (rsp_cell_size),
      .rsp_cell_color (rsp_cell_color),
      .rsp_last_cell  (rsp_last_cell)
   );

   // Track queued words that have not been fetched yet
   always_comb begin
      count_in = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   `ASSERT_NEVER(a_count_bound, clock, reset, count_ff > CNT_W'(FIFO_DEPTH))
   `ASSERT_NEVER(a_fetch_empty, clock, reset, rd_en && count_ff == '0)
   `ASSERT_NEVER(a_write_full, clock, reset, wr_en && count_ff == CNT_W'(FIFO_DEPTH))
   `ASSERT_PROP(a_fetch_moves_ptr, clock, reset, rd_en |=> rd_ptr != $past(rd_ptr))

endmodule
